// File: design/bba_pkg.sv
// Package for the buddy block allocator: sizes, codes and shared types.
// Used by the controller, datapath, top level and testbench; depends on nothing.
package bba_pkg;

    localparam int MIN_ORDER  = 5;
    localparam int LEVELS     = 8;
    localparam int TOP_BLOCKS = 4;
    localparam int TOP_LEVEL  = LEVELS - 1;
    localparam int L0_COUNT   = TOP_BLOCKS << TOP_LEVEL;
    localparam int MAP_BITS   = TOP_BLOCKS * ((1 << LEVELS) - 1);
    localparam int MAP_AW     = $clog2(MAP_BITS);
    localparam int IDX_W      = $clog2(L0_COUNT);
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int TOP_SIZE   = 1 << (MIN_ORDER + TOP_LEVEL);

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOSPC  = 2'd1;
    localparam logic [1:0] ST_BADSZ  = 2'd2;
    localparam logic       REQ_ALLOC = 1'b0;
    localparam logic       REQ_FREE  = 1'b1;

    // Datapath operations chosen by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD,
        OP_SCAN_NEXT,
        OP_CLR_FOUND,
        OP_SPLIT,
        OP_FREE_RD,
        OP_MERGE,
        OP_SET_FREE,
        OP_CLEAR_WR
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic bad_size;
        logic is_free;
        logic rd_bit;
        logic scan_last;
        logic lvl_top;
        logic lvl_at_want;
        logic blk_in_range;
        logic clear_done;
    } stat_t;

    // First map address of a level.
    function automatic logic [MAP_AW-1:0] level_base(input logic [LVL_W-1:0] lvl);
        logic [MAP_AW:0] base;
        base = '0;
        for (int k = 0; k < LEVELS; k++) begin
            if (k < int'(lvl)) begin
                base = base + (MAP_AW+1)'(TOP_BLOCKS << (TOP_LEVEL - k));
            end
        end
        return base[MAP_AW-1:0];
    endfunction

    // Block count of a level.
    function automatic logic [IDX_W:0] level_count(input logic [LVL_W-1:0] lvl);
        return (IDX_W+1)'(L0_COUNT) >> lvl;
    endfunction

endpackage

// File: design/bba_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on nothing; the payload type is set per instance.
interface bba_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/bba_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module bba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Registered read; a read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: design/bba_datapath.sv
// Datapath: request registers, level and index counters, free map memory.
// Depends on bba_pkg and bba_ram.
module bba_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bba_pkg::cmd_t            cmd,
    output bba_pkg::stat_t           stat,
    input  logic                     in_type,
    input  logic [12:0]              in_size,
    input  logic [13:0]              in_offset,
    output logic [13:0]              res_offset
);
    logic                        type_reg;
    logic [bba_pkg::LVL_W-1:0]   want_reg, lvl_reg;
    logic [bba_pkg::IDX_W-1:0]   idx_reg;
    logic                        bad_reg, inrange_reg;
    logic [bba_pkg::MAP_AW:0]    clr_reg;
    logic [bba_pkg::LVL_W:0]     want_c;
    logic                        bad_c;
    logic [bba_pkg::IDX_W-1:0]   blk_c;
    logic                        we;
    logic                        wdata;
    logic [bba_pkg::MAP_AW-1:0]  addr;
    logic [bba_pkg::IDX_W-1:0]   aidx;
    logic [bba_pkg::IDX_W:0]     cnt;
    logic                        rdata;
    logic [13:0]                 off_full;

    // Size to level: count orders below the size.
    always_comb
    begin
        want_c = '0;
        bad_c  = (in_size == 13'd0) || (32'(in_size) > 32'(bba_pkg::TOP_SIZE));
        for (int k = 0; k < bba_pkg::TOP_LEVEL; k++) begin
            if (32'(in_size) > (32'd1 << (bba_pkg::MIN_ORDER + k)))
            begin
                want_c = (bba_pkg::LVL_W+1)'(k + 1);
            end
        end
    end

    assign cnt = bba_pkg::level_count(lvl_reg);

    // Memory address mux.
    always_comb
    begin
        aidx  = idx_reg;
        we    = 1'b0;
        wdata = 1'b0;
        case (cmd.op)
            bba_pkg::OP_FREE_RD: aidx = idx_reg ^ bba_pkg::IDX_W'(1);
            bba_pkg::OP_MERGE:   begin aidx = idx_reg ^ bba_pkg::IDX_W'(1); we = 1'b1; end
            bba_pkg::OP_CLR_FOUND: we = 1'b1;
            bba_pkg::OP_SPLIT:   begin aidx = {idx_reg[bba_pkg::IDX_W-2:0], 1'b1}; we = 1'b1;
                                 wdata = 1'b1; end
            bba_pkg::OP_SET_FREE: begin we = inrange_reg; wdata = 1'b1; end
            default: ;
        endcase
        addr = bba_pkg::level_base(cmd.op == bba_pkg::OP_SPLIT ?
                                   lvl_reg - bba_pkg::LVL_W'(1) : lvl_reg)
             + bba_pkg::MAP_AW'(aidx);
        if (cmd.op == bba_pkg::OP_CLEAR_WR)
        begin
            addr  = clr_reg[bba_pkg::MAP_AW-1:0];
            we    = 1'b1;
            wdata = (32'(clr_reg) >= 32'(bba_pkg::MAP_BITS - bba_pkg::TOP_BLOCKS));
        end
    end

    bba_ram #(.WIDTH(1), .DEPTH(bba_pkg::MAP_BITS)) u_map (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign blk_c = bba_pkg::IDX_W'(in_offset >> (bba_pkg::MIN_ORDER + 32'(want_c)));

    // Counters and request registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.op == bba_pkg::OP_CLEAR_WR)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bba_pkg::OP_LOAD:
            begin
                type_reg    <= in_type;
                bad_reg     <= bad_c;
                want_reg    <= want_c[bba_pkg::LVL_W-1:0];
                lvl_reg     <= want_c[bba_pkg::LVL_W-1:0];
                idx_reg     <= in_type ? blk_c : '0;
                inrange_reg <= (14'(in_offset >> (bba_pkg::MIN_ORDER + 32'(want_c)))
                                < 14'(bba_pkg::level_count(want_c[bba_pkg::LVL_W-1:0])));
            end
            bba_pkg::OP_SCAN_NEXT:
            begin
                if ((bba_pkg::IDX_W+1)'(idx_reg) + 1'b1 >= cnt)
                begin
                    idx_reg <= '0;
                    lvl_reg <= lvl_reg + 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            bba_pkg::OP_SPLIT:
            begin
                lvl_reg <= lvl_reg - 1'b1;
                idx_reg <= {idx_reg[bba_pkg::IDX_W-2:0], 1'b0};
            end
            bba_pkg::OP_MERGE:
            begin
                lvl_reg <= lvl_reg + 1'b1;
                idx_reg <= idx_reg >> 1;
            end
            default: ;
        endcase
    end

    assign off_full = 14'(32'(idx_reg) << (bba_pkg::MIN_ORDER + 32'(lvl_reg)));
    assign res_offset = off_full;

    assign stat.bad_size     = bad_reg;
    assign stat.is_free      = type_reg;
    assign stat.rd_bit       = rdata;
    assign stat.scan_last    = ((bba_pkg::IDX_W+1)'(idx_reg) + 1'b1 >= cnt);
    assign stat.lvl_top      = (32'(lvl_reg) == bba_pkg::TOP_LEVEL);
    assign stat.lvl_at_want  = (lvl_reg == want_reg);
    assign stat.blk_in_range = inrange_reg;
    assign stat.clear_done   = (32'(clr_reg) == bba_pkg::MAP_BITS - 1);
endmodule

// File: design/bba_ctrl.sv
// Controller state machine sequencing clear, scan, split and merge.
// Depends on bba_pkg.
module bba_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output logic [1:0]     rsp_status,
    output logic           rsp_zero,
    output bba_pkg::cmd_t  cmd,
    input  bba_pkg::stat_t stat
);
    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_DEC   = 9'b000000100,
        S_SRD   = 9'b000001000,
        S_SCHK  = 9'b000010000,
        S_SPLIT = 9'b000100000,
        S_FRD   = 9'b001000000,
        S_FCHK  = 9'b010000000,
        S_RESP  = 9'b100000000
    } state_t;

    state_t    state_reg, state_next;
    logic [1:0] st_reg, st_next;
    logic       zero_reg, zero_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        zero_next  = zero_reg;
        cmd.op     = bba_pkg::OP_NONE;
        req_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = bba_pkg::OP_CLEAR_WR;
                if (stat.clear_done) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op = bba_pkg::OP_LOAD;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                st_next = bba_pkg::ST_OK;
                zero_next = 1'b1;
                if (stat.bad_size)
                begin
                    st_next = bba_pkg::ST_BADSZ;
                    state_next = S_RESP;
                end
                else if (stat.is_free)
                begin
                    if (!stat.blk_in_range) state_next = S_RESP;
                    else if (stat.lvl_top)
                    begin
                        cmd.op = bba_pkg::OP_SET_FREE;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.op = bba_pkg::OP_FREE_RD;
                        state_next = S_FCHK;
                    end
                end
                else
                begin
                    cmd.op = bba_pkg::OP_RD;
                    state_next = S_SCHK;
                end
            end
            S_SRD:
            begin
                cmd.op = bba_pkg::OP_RD;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (stat.rd_bit)
                begin
                    cmd.op = bba_pkg::OP_CLR_FOUND;
                    state_next = S_SPLIT;
                end
                else if (stat.scan_last && stat.lvl_top)
                begin
                    st_next = bba_pkg::ST_NOSPC;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op = bba_pkg::OP_SCAN_NEXT;
                    state_next = S_SRD;
                end
            end
            S_SPLIT:
            begin
                if (stat.lvl_at_want)
                begin
                    zero_next = 1'b0;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op = bba_pkg::OP_SPLIT;
                end
            end
            S_FRD:
            begin
                if (stat.lvl_top)
                begin
                    cmd.op = bba_pkg::OP_SET_FREE;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op = bba_pkg::OP_FREE_RD;
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (stat.rd_bit)
                begin
                    cmd.op = bba_pkg::OP_MERGE;
                    state_next = S_FRD;
                end
                else
                begin
                    cmd.op = bba_pkg::OP_SET_FREE;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            st_reg    <= bba_pkg::ST_OK;
            zero_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            zero_reg  <= zero_next;
        end
    end

    assign rsp_valid  = (state_reg == S_RESP);
    assign rsp_status = st_reg;
    assign rsp_zero   = zero_reg;
endmodule

// File: design/buddy_block_allocator.sv
// Top level of the buddy block allocator.
// Depends on bba_pkg, bba_if, bba_ctrl, bba_datapath.
//   channel | dir | payload
//   req     | in  | req_type, req_size, free_offset
//   rsp     | out | block_offset, status
// One request at a time: an allocate reads then checks each free-map bit in turn
// and splits one level per cycle; a free reads and merges one level at a time.
// Bad sizes go from decode straight to the response.
// After reset a clearing pass writes all MAP_BITS (1020) map bits before req_ready.
// A response holds in its register until rsp_ready.
module buddy_block_allocator (
    input logic clk,
    input logic rst_n,
    bba_if.sink   req,
    bba_if.source rsp
);
    bba_pkg::cmd_t  cmd;
    bba_pkg::stat_t stat;
    logic [13:0]    off;
    logic [1:0]     st;
    logic           zero;

    bba_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req.valid), .req_ready(req.ready),
        .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
        .rsp_status(st), .rsp_zero(zero),
        .cmd(cmd), .stat(stat)
    );

    bba_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_type(req.data.req_type), .in_size(req.data.req_size),
        .in_offset(req.data.free_offset), .res_offset(off)
    );

    assign rsp.data.block_offset = zero ? 14'd0 : off;
    assign rsp.data.status       = st;
endmodule

// File: design/bba_checker.sv
// Port-level checker for the buddy block allocator, bound to the top level.
// Depends on the top level's ports only.
module bba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [13:0] block_offset,
    input logic [1:0]  status
);
    // No new request while a response is pending.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready) else $error("ready with response pending");
    // Failed results carry a zero offset.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != 2'd0 |-> block_offset == 14'd0) else $error("offset nonzero");
    // Status is never the unused code.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status != 2'd3) else $error("bad status");
    // Response holds while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)) else $error("dropped");
    // Accepting a request does not give a response in the next cycle.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !rsp_valid) else $error("too fast");
endmodule

bind buddy_block_allocator bba_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .block_offset(rsp.data.block_offset), .status(rsp.data.status)
);

// File: tb/tb_bba_types_pkg.sv
`timescale 1ns / 1ps
// Request and response payload types for the buddy allocator testbench.
// Depends on nothing; used by the scoreboard and the testbench top.
package tb_bba_types_pkg;

    typedef struct packed {
        logic        req_type;
        logic [12:0] req_size;
        logic [13:0] free_offset;
    } alloc_req_t;

    typedef struct packed {
        logic [13:0] block_offset;
        logic [1:0]  status;
    } alloc_rsp_t;

endpackage

// File: tb/bba_scoreboard.sv
`timescale 1ns / 1ps
// Watches the request and response channels, predicts each response from its own
// copy of the free map and compares. Depends on bba_pkg and tb_bba_types_pkg.
module bba_scoreboard
    import bba_pkg::*;
    import tb_bba_types_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_ready,
    input  alloc_req_t req_data,
    input  logic       rsp_valid,
    input  logic       rsp_ready,
    input  alloc_rsp_t rsp_data,
    output int         fail_count,
    output int         awaited
);

    // One bit per block of every level; set means free.
    bit         free_bits [0:TOP_LEVEL][0:L0_COUNT-1];
    alloc_rsp_t expected_rsp_q [$];
    int         mismatches;

    function automatic int blocks_at(input int lvl);
        return TOP_BLOCKS << (TOP_LEVEL - lvl);
    endfunction

    // Level for a size, or -1 when the size is out of range.
    function automatic int order_of_size(input int size);
        int ord;
        ord = 0;
        if (size == 0 || size > TOP_SIZE)
        begin
            return -1;
        end
        while ((1 << ord) < size)
        begin
            ord++;
        end
        if (ord < MIN_ORDER)
        begin
            ord = MIN_ORDER;
        end
        return ord - MIN_ORDER;
    endfunction

    // Apply one request to the map and work out its response.
    task automatic serve_request(input alloc_req_t r, output alloc_rsp_t e);
        int  want;
        int  lvl;
        int  idx;
        int  blk;
        bit  found;
        want           = order_of_size(int'(r.req_size));
        e.block_offset = '0;
        e.status       = ST_OK;
        found          = 1'b0;
        idx            = 0;
        if (want < 0)
        begin
            e.status = ST_BADSZ;
        end
        else if (r.req_type == REQ_ALLOC)
        begin
            lvl = want;
            while (lvl <= TOP_LEVEL && !found)
            begin
                for (idx = 0; idx < blocks_at(lvl); idx++)
                begin
                    if (free_bits[lvl][idx])
                    begin
                        found = 1'b1;
                        break;
                    end
                end
                if (!found)
                begin
                    lvl++;
                end
            end
            if (!found)
            begin
                e.status = ST_NOSPC;
            end
            else
            begin
                free_bits[lvl][idx] = 1'b0;
                while (lvl > want)
                begin
                    lvl--;
                    idx = idx << 1;
                    free_bits[lvl][idx | 1] = 1'b1;
                end
                e.block_offset = 14'(idx << (MIN_ORDER + lvl));
            end
        end
        else
        begin
            lvl = want;
            blk = int'(r.free_offset) >> (MIN_ORDER + lvl);
            if (blk < blocks_at(lvl))
            begin
                idx = blk;
                while (lvl < TOP_LEVEL && free_bits[lvl][idx ^ 1])
                begin
                    free_bits[lvl][idx ^ 1] = 1'b0;
                    idx = idx >> 1;
                    lvl++;
                end
                free_bits[lvl][idx] = 1'b1;
            end
        end
    endtask

    assign awaited = expected_rsp_q.size();

    // Predict on each accepted request, compare on each accepted response.
    always @(posedge clk or negedge rst_n)
    begin
        alloc_rsp_t e;
        alloc_rsp_t want_rsp;
        if (!rst_n)
        begin
            for (int l = 0; l <= TOP_LEVEL; l++)
            begin
                for (int i = 0; i < L0_COUNT; i++)
                begin
                    free_bits[l][i] = (l == TOP_LEVEL && i < TOP_BLOCKS);
                end
            end
            expected_rsp_q.delete();
            fail_count <= 0;
            mismatches = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: response with nothing pending: off=%0d st=%0d",
                                 rsp_data.block_offset, rsp_data.status);
                    end
                end
                else
                begin
                    want_rsp = expected_rsp_q.pop_front();
                    if (want_rsp.block_offset !== rsp_data.block_offset ||
                        want_rsp.status !== rsp_data.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("ERROR: expected off=%0d st=%0d, got off=%0d st=%0d",
                                     want_rsp.block_offset, want_rsp.status,
                                     rsp_data.block_offset, rsp_data.status);
                        end
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                serve_request(req_data, e);
                expected_rsp_q.push_back(e);
            end
            fail_count <= mismatches;
        end
    end

endmodule

// File: tb/tb_buddy_block_allocator.sv
`timescale 1ns / 1ps
// Testbench top for the buddy block allocator: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on bba_pkg, bba_if, the DUT,
// tb_bba_types_pkg and bba_scoreboard.
module tb_buddy_block_allocator;
    import bba_pkg::*;
    import tb_bba_types_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;

    bba_if #(.payload_t(alloc_req_t)) req (.clk(clk));
    bba_if #(.payload_t(alloc_rsp_t)) rsp (.clk(clk));

    buddy_block_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    int fail_count;
    int awaited;

    bba_scoreboard checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_ready  (req.ready),
        .req_data   (req.data),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .rsp_data   (rsp.data),
        .fail_count (fail_count),
        .awaited    (awaited)
    );

    typedef struct {
        logic [13:0] offset;
        logic [12:0] size;
    } live_block_t;

    int          tx_idle_pct;
    int          rx_idle_pct;
    alloc_req_t  sent_q [$];
    live_block_t live_q [$];
    int          outstanding;
    int          n_alloc_ok;
    int          n_nospace;
    int          n_badsize;
    int          n_free;
    int          stall_cycles;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Response back-pressure.
    always @(posedge clk)
    begin
        rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Track responses so frees can target blocks that are actually held.
    always @(posedge clk)
    begin
        alloc_req_t r;
        live_block_t lb;
        if (rst_n && rsp.valid && rsp.ready && sent_q.size() > 0)
        begin
            r = sent_q.pop_front();
            outstanding--;
            if (rsp.data.status == ST_BADSZ)
            begin
                n_badsize++;
            end
            else if (r.req_type == REQ_FREE)
            begin
                n_free++;
            end
            else if (rsp.data.status == ST_NOSPC)
            begin
                n_nospace++;
            end
            else
            begin
                n_alloc_ok++;
                lb.offset = rsp.data.block_offset;
                lb.size   = r.req_size;
                live_q.push_back(lb);
            end
        end
    end

    // Watchdog on cycles where neither channel moves.
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("buddy_block_allocator verification failed");
                $finish;
            end
        end
    end

    // Present one request and hold it until accepted.
    task automatic send_request(input alloc_req_t r);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= r;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        sent_q.push_back(r);
        outstanding++;
    endtask

    task automatic send_alloc(input int size);
        alloc_req_t r;
        r.req_type    = REQ_ALLOC;
        r.req_size    = 13'(size);
        r.free_offset = 14'($urandom);
        send_request(r);
    endtask

    task automatic send_free(input int size, input int offset);
        alloc_req_t r;
        r.req_type    = REQ_FREE;
        r.req_size    = 13'(size);
        r.free_offset = 14'(offset);
        send_request(r);
    endtask

    // Give back a random held block; optionally spoil its low offset bits.
    task automatic free_live(input bit misalign);
        int          k;
        live_block_t lb;
        k  = $urandom_range(live_q.size() - 1);
        lb = live_q[k];
        live_q.delete(k);
        send_free(lb.size, misalign ? (lb.offset | $urandom_range(31)) : lb.offset);
    endtask

    // Stop presenting requests and wait until every response has come back.
    task automatic wait_drained();
        req.valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly well-formed allocate/free traffic with some noise.
    task automatic random_phase(input int count);
        int sel;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 85)
            begin
                if (live_q.size() > 0 && $urandom_range(1))
                begin
                    free_live(1'b0);
                end
                else if ($urandom_range(9) < 8)
                begin
                    send_alloc($urandom_range(512, 1));
                end
                else
                begin
                    send_alloc($urandom_range(TOP_SIZE, 1));
                end
            end
            else if (sel < 90)
            begin
                send_alloc($urandom_range(1) ? 0 : $urandom_range(8191, TOP_SIZE + 1));
            end
            else if (sel < 94)
            begin
                send_free($urandom_range(1) ? 0 : $urandom_range(8191, TOP_SIZE + 1),
                          $urandom_range(16383));
            end
            else if (sel < 97 && live_q.size() > 0)
            begin
                free_live(1'b1);
            end
            else
            begin
                // Arbitrary free, possibly a double free or a wrong size.
                send_free($urandom_range(TOP_SIZE, 1), $urandom_range(16383));
            end
        end
    endtask

    // Main stimulus.
    initial
    begin
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.data    = '0;
        rsp.ready   = 1'b0;
        tx_idle_pct = 13;
        rx_idle_pct = 66;
        outstanding = 0;
        n_alloc_ok  = 0;
        n_nospace   = 0;
        n_badsize   = 0;
        n_free      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: size extremes, bad sizes, misalignment, exhaustion.
        send_alloc(1);
        send_alloc(32);
        send_alloc(33);
        send_alloc(TOP_SIZE);
        send_alloc(0);
        send_alloc(TOP_SIZE + 1);
        send_alloc(8191);
        send_free(0, 16383);
        send_free(8191, 0);
        wait_drained();
        free_live(1'b1);
        for (int k = 0; k < 4; k++)
        begin
            send_alloc(TOP_SIZE);
        end
        send_alloc(1);
        wait_drained();
        while (live_q.size() > 0)
        begin
            free_live(1'b0);
        end
        send_alloc(4095);
        send_alloc(64);
        wait_drained();

        // Random phases with changing idle patterns.
        random_phase(165);
        tx_idle_pct = 66;
        rx_idle_pct = 13;
        random_phase(80);
        wait_drained();
        random_phase(85);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(170);

        wait_drained();
        repeat (3000) @(posedge clk);
        $display("Covered %0d good allocations, %0d no-space, %0d bad sizes, %0d frees.",
                 n_alloc_ok, n_nospace, n_badsize, n_free);
        if (fail_count == 0 && awaited == 0)
        begin
            $display("buddy_block_allocator verification clean");
        end
        else
        begin
            $display("buddy_block_allocator verification failed");
        end
        $finish;
    end

endmodule
